FILE: rtl/cordic_sin_cos_from_degrees_unit_assert.svh
// Assertion macros shared by the CORDIC sine/cosine RTL.
// Needs nothing else; include it inside a module after its signals are declared.
`ifndef CORDIC_SIN_COS_FROM_DEGREES_UNIT_ASSERT_SVH
`define CORDIC_SIN_COS_FROM_DEGREES_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CSC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cordic_sc: same-cycle assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cordic_sc: next-cycle assertion failed");

`endif

FILE: rtl/cordic_sc_pkg.sv
// Types, constants and the arctangent table of the CORDIC sine/cosine unit.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cordic_sc_pkg;

   // Angle in whole degrees and Q14 sample types.
   typedef logic signed [8:0]  angle_type;
   typedef logic signed [15:0] q14_type;

   // Working width of the folding arithmetic and its product.
   typedef logic signed [9:0]  fold_type;
   typedef logic signed [19:0] product_type;

   localparam int ATAN_ENTRIES = 14;

   localparam q14_type  START_X        = 16'sh26DD;
   localparam fold_type DEG_TO_RAD_Q14 = 10'sd286;
   localparam fold_type HALF_TURN      = 10'sd180;
   localparam fold_type QUARTER_TURN   = 10'sd90;

   // One CORDIC pipeline stage: the rotated vector, the residual angle and
   // whether the final result has to be negated.
   typedef struct packed {
      q14_type x;
      q14_type y;
      q14_type z;
      logic    flip;
   } stage_type;

   // atan(2^-k) in Q14 radians.
   function automatic q14_type atan_q14(input logic [3:0] idx);
      q14_type val;
      case (idx)
         4'd0:    val = 16'sh3243;
         4'd1:    val = 16'sh1DAC;
         4'd2:    val = 16'sh0FAD;
         4'd3:    val = 16'sh07F5;
         4'd4:    val = 16'sh03FE;
         4'd5:    val = 16'sh01FF;
         4'd6:    val = 16'sh00FF;
         4'd7:    val = 16'sh007F;
         4'd8:    val = 16'sh003F;
         4'd9:    val = 16'sh001F;
         4'd10:   val = 16'sh000F;
         4'd11:   val = 16'sh0007;
         4'd12:   val = 16'sh0003;
         4'd13:   val = 16'sh0001;
         default: val = 16'sh0000;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/cordic_sc_if.sv
// Valid/ready channel interfaces for the angle requests and the sine/cosine responses.
// Depends on cordic_sc_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface cordic_sc_req_if
   import cordic_sc_pkg::*;
   ();
   logic      valid;
   logic      ready;
   angle_type angle_deg;

   modport source (output valid, output angle_deg, input ready);
   modport sink   (input valid, input angle_deg, output ready);
endinterface

interface cordic_sc_rsp_if
   import cordic_sc_pkg::*;
   ();
   logic    valid;
   logic    ready;
   q14_type sine_q14;
   q14_type cosine_q14;

   modport source (output valid, output sine_q14, output cosine_q14, input ready);
   modport sink   (input valid, input sine_q14, input cosine_q14, output ready);
endinterface

`default_nettype wire

FILE: rtl/cordic_sin_cos_from_degrees_unit.sv
// Path: a request moves through stage registers 0 to NUM_STEPS, then the response register.
// Throughput: one angle per cycle; the unrolled CORDIC pipeline, one rotation per stage,
// sets that figure, and a stalled response freezes the whole pipeline in place.
// Reset: synchronous, active high; clears all valid bits, the data registers keep garbage.
// Depends on cordic_sc_pkg, cordic_sc_if.sv and cordic_sin_cos_from_degrees_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

module cordic_sin_cos_from_degrees_unit
   import cordic_sc_pkg::*;
#(
   parameter int ITERATIONS = 14
) (
   input  wire              clock,
   input  wire              reset,
   cordic_sc_req_if.sink    req_ch,
   cordic_sc_rsp_if.source  rsp_ch
);

   // The table holds fourteen entries, so more rotations than that are never done.
   localparam int NUM_STEPS = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;

   // The pipeline is a chain of NUM_STEPS + 1 stage registers followed by the
   // response register. Stage 0 holds the folded angle converted to Q14 radians,
   // stage k + 1 holds the vector after rotation k. Every register moves on the
   // same enable, so a valid bit always travels with its data and a stall
   // neither drops nor duplicates a transfer.
   stage_type              stage_ff [0:NUM_STEPS];
   stage_type              stage0_in;
   stage_type              stage_in [1:NUM_STEPS];
   logic [NUM_STEPS:0]     stage_valid_ff;

   logic                   rsp_valid_ff;
   q14_type                rsp_sine_ff;
   q14_type                rsp_cosine_ff;
   q14_type                rsp_sine_in;
   q14_type                rsp_cosine_in;

   logic                   advance;

   // The pipeline advances whenever the response register is empty or its
   // contents are being taken in this cycle. The request ready is that same
   // signal, so no new angle is accepted while a finished result waits.
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // Front end: fold the angle into -90..90 degrees and scale it to radians.
   // An angle above 90 degrees loses a half turn, one below -90 gains one;
   // both cases negate the final sine and cosine. Any 9-bit input folds into
   // a range whose product with 286 fits in 16 bits.
   always_comb begin
      fold_type    deg;
      fold_type    folded;
      product_type z_wide;
      logic        flip;

      deg    = fold_type'(req_ch.angle_deg);
      folded = deg;
      flip   = 1'b0;
      if (deg > QUARTER_TURN) begin
         folded = deg - HALF_TURN;
         flip   = 1'b1;
      end else if (deg < -QUARTER_TURN) begin
         folded = deg + HALF_TURN;
         flip   = 1'b1;
      end
      z_wide = product_type'(folded) * product_type'(DEG_TO_RAD_Q14);

      stage0_in.x    = START_X;
      stage0_in.y    = 16'sd0;
      stage0_in.z    = z_wide[15:0];
      stage0_in.flip = flip;
   end

   // Rotation stages. Each stage rotates toward a zero residual angle by
   // atan(2^-k), with 16-bit arithmetic shifts and wrapping sums.
   always_comb begin
      stage_type cur;
      q14_type   dx;
      q14_type   dy;

      for (int k = 0; k < NUM_STEPS; k++) begin
         cur = stage_ff[k];
         dx  = cur.y >>> k;
         dy  = cur.x >>> k;
         stage_in[k + 1].flip = cur.flip;
         if (cur.z[15]) begin
            stage_in[k + 1].x = cur.x + dx;
            stage_in[k + 1].y = cur.y - dy;
            stage_in[k + 1].z = cur.z + atan_q14(4'(k));
         end else begin
            stage_in[k + 1].x = cur.x - dx;
            stage_in[k + 1].y = cur.y + dy;
            stage_in[k + 1].z = cur.z - atan_q14(4'(k));
         end
      end
   end

   // Back end: undo the half-turn fold by negating both results.
   always_comb begin
      if (stage_ff[NUM_STEPS].flip) begin
         rsp_sine_in   = -stage_ff[NUM_STEPS].y;
         rsp_cosine_in = -stage_ff[NUM_STEPS].x;
      end else begin
         rsp_sine_in   = stage_ff[NUM_STEPS].y;
         rsp_cosine_in = stage_ff[NUM_STEPS].x;
      end
   end

   // Valid bits and the response valid are control state and see the reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         stage_valid_ff <= {stage_valid_ff[NUM_STEPS-1:0], req_ch.valid};
         rsp_valid_ff   <= stage_valid_ff[NUM_STEPS];
      end
   end

   // Data registers need no reset; only the valid bits qualify them.
   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff[0] <= stage0_in;
         for (int k = 1; k <= NUM_STEPS; k++) begin
            stage_ff[k] <= stage_in[k];
         end
         rsp_sine_ff   <= rsp_sine_in;
         rsp_cosine_ff <= rsp_cosine_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sine_q14   = rsp_sine_ff;
   assign rsp_ch.cosine_q14 = rsp_cosine_ff;

   // Assertions.
`include "cordic_sin_cos_from_degrees_unit_assert.svh"

   // An accepted request enters the first stage.
   `CSC_ASSERT_NEXT(a_req_enters, clock, reset, req_ch.valid && req_ch.ready, stage_valid_ff[0])
   // While the pipeline is stalled nothing in it moves.
   `CSC_ASSERT_NEXT(a_stall_holds, clock, reset, !advance, $stable(stage_valid_ff))
   // The last stage reaches the response register when the pipeline moves.
   `CSC_ASSERT_NEXT(a_last_to_rsp, clock, reset, advance && stage_valid_ff[NUM_STEPS], rsp_valid_ff)
   // Folding keeps the starting angle within plus or minus 90 degrees in Q14.
   `CSC_ASSERT_IMPLY(a_fold_range, clock, reset, stage_valid_ff[0], (stage_ff[0].z <= 16'sd25740) && (stage_ff[0].z >= -16'sd25740))

endmodule

`default_nettype wire
